// File: rtl/ifbs_pkg.sv
`timescale 1ns / 1ps

package ifbs_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int FIFO_DEPTH_DEF = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_FLAG        = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ADDRESS     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CTRL_SEQ0   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CTRL_SEQ1   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ESCAPE      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ESC_FLAG    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_ESC_ESCAPE  = 3'd6;

    localparam logic [BYTE_W-1:0] RST_FLAG       = 8'd126;
    localparam logic [BYTE_W-1:0] RST_ADDRESS    = 8'd3;
    localparam logic [BYTE_W-1:0] RST_CTRL_SEQ0  = 8'd0;
    localparam logic [BYTE_W-1:0] RST_CTRL_SEQ1  = 8'd64;
    localparam logic [BYTE_W-1:0] RST_ESCAPE     = 8'd125;
    localparam logic [BYTE_W-1:0] RST_ESC_FLAG   = 8'd94;
    localparam logic [BYTE_W-1:0] RST_ESC_ESCAPE = 8'd93;
    localparam logic [BYTE_W-1:0] XOR_INIT       = 8'h00;

    // Payload byte classes.
    localparam logic [1:0] KIND_PLAIN  = 2'd0;
    localparam logic [1:0] KIND_FLAG   = 2'd1;
    localparam logic [1:0] KIND_ESCAPE = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_code;
        logic [BYTE_W-1:0] address_code;
        logic [BYTE_W-1:0] control_seq0;
        logic [BYTE_W-1:0] control_seq1;
        logic [BYTE_W-1:0] escape_code;
        logic [BYTE_W-1:0] escaped_flag_code;
        logic [BYTE_W-1:0] escaped_escape_code;
    } t_cfg;

    // One classified payload byte, as queued between front and back.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [1:0]        kind;
        logic              first;
        logic              last;
        logic              seq;
        logic [BYTE_W-1:0] bcc2;
    } t_item;

endpackage

// File: rtl/ifbs_front.sv
`timescale 1ns / 1ps

module ifbs_front
    import ifbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_data,
    input  logic              i_first,
    input  logic              i_last,
    input  logic              i_seq,
    output t_item             o_item
);

    logic [BYTE_W-1:0] r_xor;
    logic [BYTE_W-1:0] n_xor;
    logic [BYTE_W-1:0] w_sum;
    logic [1:0]        w_kind;

    always_comb begin
        w_sum = (i_first ? XOR_INIT : r_xor) ^ i_data;
        // The flag substitution wins when both codes are equal.
        if (i_data == i_cfg.flag_code) begin
            w_kind = KIND_FLAG;
        end else if (i_data == i_cfg.escape_code) begin
            w_kind = KIND_ESCAPE;
        end else begin
            w_kind = KIND_PLAIN;
        end
        n_xor = r_xor;
        if (i_accept) begin
            n_xor = i_last ? XOR_INIT : w_sum;
        end
        o_item.data  = i_data;
        o_item.kind  = w_kind;
        o_item.first = i_first;
        o_item.last  = i_last;
        o_item.seq   = i_seq;
        o_item.bcc2  = w_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor <= XOR_INIT;
        end else begin
            r_xor <= n_xor;
        end
    end

endmodule

// File: rtl/ifbs_fifo.sv
`timescale 1ns / 1ps

module ifbs_fifo
    import ifbs_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: rtl/ifbs_back.sv
`timescale 1ns / 1ps

module ifbs_back
    import ifbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_item             i_item,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [BYTE_W-1:0] o_tdata,
    output logic              o_tlast
);

    localparam logic [2:0] PH_FLAG = 3'd0;
    localparam logic [2:0] PH_ADDR = 3'd1;
    localparam logic [2:0] PH_CTRL = 3'd2;
    localparam logic [2:0] PH_BCC1 = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_SUB  = 3'd5;
    localparam logic [2:0] PH_BCC2 = 3'd6;
    localparam logic [2:0] PH_END  = 3'd7;

    logic              r_mid;
    logic [2:0]        r_phase;
    logic              r_tvalid;
    logic [BYTE_W-1:0] r_tdata;
    logic              r_tlast;
    logic              n_mid;
    logic [2:0]        n_phase;
    logic              n_tvalid;
    logic [BYTE_W-1:0] n_tdata;
    logic              n_tlast;

    logic [2:0]        w_phase;
    logic [2:0]        w_next;
    logic              w_done;
    logic              w_load;
    logic [BYTE_W-1:0] w_ctrl;
    logic [BYTE_W-1:0] w_byte;
    logic              w_end;

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;

    // The output register refills whenever it is empty or being drained and the queue holds an item.
    assign w_load = !i_empty && (!r_tvalid || i_tready);
    assign o_pop  = w_load && w_done;

    always_comb begin
        w_phase = r_mid ? r_phase : (i_item.first ? PH_FLAG : PH_DATA);
        w_ctrl  = i_item.seq ? i_cfg.control_seq1 : i_cfg.control_seq0;
        w_next  = w_phase;
        w_done  = 1'b0;
        w_end   = 1'b0;
        w_byte  = i_item.data;
        case (w_phase)
            PH_FLAG: begin
                w_byte = i_cfg.flag_code;
                w_next = PH_ADDR;
            end
            PH_ADDR: begin
                w_byte = i_cfg.address_code;
                w_next = PH_CTRL;
            end
            PH_CTRL: begin
                w_byte = w_ctrl;
                w_next = PH_BCC1;
            end
            PH_BCC1: begin
                w_byte = i_cfg.address_code ^ w_ctrl;
                w_next = PH_DATA;
            end
            PH_DATA: begin
                if (i_item.kind == KIND_PLAIN) begin
                    w_byte = i_item.data;
                    w_next = PH_BCC2;
                    w_done = !i_item.last;
                end else begin
                    w_byte = i_cfg.escape_code;
                    w_next = PH_SUB;
                end
            end
            PH_SUB: begin
                w_byte = (i_item.kind == KIND_FLAG) ? i_cfg.escaped_flag_code
                                                    : i_cfg.escaped_escape_code;
                w_next = PH_BCC2;
                w_done = !i_item.last;
            end
            PH_BCC2: begin
                w_byte = i_item.bcc2;
                w_next = PH_END;
            end
            PH_END: begin
                w_byte = i_cfg.flag_code;
                w_end  = 1'b1;
                w_done = 1'b1;
            end
            default: begin
                w_byte = i_item.data;
                w_done = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_mid    = r_mid;
        n_phase  = r_phase;
        n_tvalid = r_tvalid;
        n_tdata  = r_tdata;
        n_tlast  = r_tlast;
        if (w_load) begin
            n_tvalid = 1'b1;
            n_tdata  = w_byte;
            n_tlast  = w_end;
            n_mid    = !w_done;
            n_phase  = w_next;
        end else if (i_tready) begin
            n_tvalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid    <= 1'b0;
            r_phase  <= PH_FLAG;
            r_tvalid <= 1'b0;
        end else begin
            r_mid    <= n_mid;
            r_phase  <= n_phase;
            r_tvalid <= n_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tdata <= n_tdata;
        r_tlast <= n_tlast;
    end

endmodule

// File: rtl/info_frame_byte_stuffer_core.sv
`timescale 1ns / 1ps

// Byte-stuffing framer for information frames. Payload bytes enter on the slave
// stream, with tuser[0] marking the first byte of a packet (header comes first) and
// tuser[1] the sequence bit; tlast marks the last byte (BCC2 and a closing flag
// follow, the flag with tlast set on the master stream). The master stream emits one
// byte per cycle while i_m_axis_tready is high and bytes are queued. An input byte
// yields 1 output byte if plain or 2 if stuffed, plus 4 for a header and 2 for a
// trailer. A queue of FIFO_DEPTH classified bytes ahead of the sequencer takes input
// transactions every cycle until it fills. Unenforced by the block, the user must
// write configuration registers via i_cfg_we/i_cfg_addr/i_cfg_wdata only while idle.

module info_frame_byte_stuffer_core
    import ifbs_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [BYTE_W-1:0]     i_s_axis_tdata,  // [7:0] data_byte
    input  logic                  i_s_axis_tlast,  // last_byte
    input  logic [1:0]            i_s_axis_tuser,  // [0] first_byte, [1] seq_bit
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [BYTE_W-1:0]     o_m_axis_tdata,  // [7:0] out_byte
    output logic                  o_m_axis_tlast,  // frame_end
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [BYTE_W-1:0]     i_cfg_wdata
);

    t_cfg  r_cfg;
    t_cfg  n_cfg;
    t_item w_push_item;
    t_item w_head;
    logic  w_full;
    logic  w_empty;
    logic  w_accept;
    logic  w_pop;

    assign o_s_axis_tready = !w_full;
    assign w_accept        = i_s_axis_tvalid && !w_full;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_FLAG:       n_cfg.flag_code           = i_cfg_wdata;
                REG_ADDRESS:    n_cfg.address_code        = i_cfg_wdata;
                REG_CTRL_SEQ0:  n_cfg.control_seq0        = i_cfg_wdata;
                REG_CTRL_SEQ1:  n_cfg.control_seq1        = i_cfg_wdata;
                REG_ESCAPE:     n_cfg.escape_code         = i_cfg_wdata;
                REG_ESC_FLAG:   n_cfg.escaped_flag_code   = i_cfg_wdata;
                REG_ESC_ESCAPE: n_cfg.escaped_escape_code = i_cfg_wdata;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_code           <= RST_FLAG;
            r_cfg.address_code        <= RST_ADDRESS;
            r_cfg.control_seq0        <= RST_CTRL_SEQ0;
            r_cfg.control_seq1        <= RST_CTRL_SEQ1;
            r_cfg.escape_code         <= RST_ESCAPE;
            r_cfg.escaped_flag_code   <= RST_ESC_FLAG;
            r_cfg.escaped_escape_code <= RST_ESC_ESCAPE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    ifbs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (w_accept),
        .i_data   (i_s_axis_tdata),
        .i_first  (i_s_axis_tuser[0]),
        .i_last   (i_s_axis_tlast),
        .i_seq    (i_s_axis_tuser[1]),
        .o_item   (w_push_item)
    );

    ifbs_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    ifbs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_item   (w_head),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule
